// ===== rtl/core/sls_pkg.sv =====
// Shared types, codes and constants for the status LED sequencer.
`timescale 1ns / 1ps

package sls_pkg;

    localparam int LEVEL_W     = 8;
    localparam int HUE_W       = 9;
    localparam int FLASH_CNT_W = 9;
    localparam int CMD_W       = 3;
    localparam int PHASE_W     = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [LEVEL_W-1:0] DIM_LEVEL    = 8'd13;
    localparam logic [LEVEL_W-1:0] PURPLE_LEVEL = 8'd6;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL   = 8'd255;
    localparam logic [LEVEL_W-1:0] BRIGHT_RESET = 8'd64;

    localparam logic [HUE_W-1:0] HUE_STEP_RESET = 9'd6;
    localparam logic [HUE_W-1:0] HUE_CIRCLE     = 9'd360;
    localparam logic [HUE_W-1:0] SECTOR_DEG     = 9'd60;

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_STEP   = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_DISCONNECTED = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CONNECTING   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CONNECTED    = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_STATUS      = 3'd0,
        CMD_BLINK       = 3'd1,
        CMD_FLASH_TICK  = 3'd2,
        CMD_RAINBOW     = 3'd3,
        CMD_FLASH_REQ   = 3'd4,
        CMD_SET_RAINBOW = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_STATUS,
        OP_BLINK,
        OP_FLASH_TICK,
        OP_RAINBOW,
        OP_FLASH_REQ,
        OP_SET_RAINBOW
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [PHASE_W-1:0]     link_phase;
        logic                   recording;
        logic                   gps_fix;
        logic [3*LEVEL_W-1:0]   flash_colour;
        logic [LEVEL_W-1:0]     flash_times;
        logic                   rainbow_on;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SECTOR,
        ST_FRAC,
        ST_MUL,
        ST_EMIT
    } bk_state_t;

endpackage

// ===== rtl/core/sls_if.sv =====
// Request, response and configuration channel interfaces.
`timescale 1ns / 1ps

interface sls_req_if;
    import sls_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [PHASE_W-1:0]   link_phase;
    logic                 recording;
    logic                 gps_fix;
    logic [LEVEL_W-1:0]   flash_red;
    logic [LEVEL_W-1:0]   flash_green;
    logic [LEVEL_W-1:0]   flash_blue;
    logic [LEVEL_W-1:0]   flash_times;
    logic                 rainbow_on;

    modport source (
        output valid, cmd, link_phase, recording, gps_fix,
               flash_red, flash_green, flash_blue, flash_times, rainbow_on,
        input  ready
    );
    modport sink (
        input  valid, cmd, link_phase, recording, gps_fix,
               flash_red, flash_green, flash_blue, flash_times, rainbow_on,
        output ready
    );
endinterface

interface sls_rsp_if;
    import sls_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 led_write;
    logic [LEVEL_W-1:0]   led_red;
    logic [LEVEL_W-1:0]   led_green;
    logic [LEVEL_W-1:0]   led_blue;

    modport source (
        output valid, led_write, led_red, led_green, led_blue,
        input  ready
    );
    modport sink (
        input  valid, led_write, led_red, led_green, led_blue,
        output ready
    );
endinterface

interface sls_cfg_if;
    import sls_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/core/sls_front.sv =====
// Front end: accepts request beats and classifies them into operations.
`timescale 1ns / 1ps

module sls_front (
    sls_req_if.sink        req,
    input  logic           full,
    output logic           push,
    output sls_pkg::item_t item
);
    import sls_pkg::*;

    assign req.ready = !full;
    assign push      = req.valid && !full;

    always_comb
    begin
        item.link_phase   = req.link_phase;
        item.recording    = req.recording;
        item.gps_fix      = req.gps_fix;
        item.flash_colour = {req.flash_red, req.flash_green, req.flash_blue};
        item.flash_times  = req.flash_times;
        item.rainbow_on   = req.rainbow_on;
        case (req.cmd)
            CMD_STATUS:      item.op = OP_STATUS;
            CMD_BLINK:       item.op = OP_BLINK;
            CMD_FLASH_TICK:  item.op = OP_FLASH_TICK;
            CMD_RAINBOW:     item.op = OP_RAINBOW;
            CMD_FLASH_REQ:   item.op = OP_FLASH_REQ;
            CMD_SET_RAINBOW: item.op = OP_SET_RAINBOW;
            default:         item.op = OP_NOP;
        endcase
    end

endmodule

// ===== rtl/core/sls_queue.sv =====
// Short queue of classified operations between front and back end.
`timescale 1ns / 1ps

module sls_queue #(
    parameter int DEPTH = sls_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sls_pkg::item_t item_in,
    output logic           full,
    input  logic           pop,
    output sls_pkg::item_t item_out,
    output logic           valid
);
    import sls_pkg::*;

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    item_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [FILL_W-1:0]  fill_next;

    assign full     = (fill_reg == FILL_W'(DEPTH));
    assign valid    = (fill_reg != '0);
    assign item_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ===== rtl/core/sls_back.sv =====
// Back end: LED state, flash and blink sequencing, HSV rainbow unit, result register.
`timescale 1ns / 1ps

module sls_back (
    input  logic           clk,
    input  logic           rst_n,
    sls_cfg_if.sink        cfg,
    input  sls_pkg::item_t item,
    input  logic           item_valid,
    output logic           pop,
    sls_rsp_if.source      rsp
);
    import sls_pkg::*;

    typedef struct packed {
        logic                keep_blink;
        logic                blink;
        logic [LEVEL_W-1:0]  red;
        logic [LEVEL_W-1:0]  green;
        logic [LEVEL_W-1:0]  blue;
    } base_t;

    function automatic base_t refresh_base(input logic [PHASE_W-1:0] phase,
                                           input logic rec, input logic gps);
        base_t b;
        b = '0;
        case (phase)
            PHASE_DISCONNECTED:
            begin
                b.red = DIM_LEVEL;
            end
            PHASE_CONNECTING:
            begin
                b.blink = 1'b1;
                b.blue  = DIM_LEVEL;
            end
            PHASE_CONNECTED:
            begin
                b.blink = rec;
                if (gps)
                begin
                    b.red  = PURPLE_LEVEL;
                    b.blue = PURPLE_LEVEL;
                end
                else
                begin
                    b.green = DIM_LEVEL;
                end
            end
            default:
            begin
                b.keep_blink = 1'b1;
            end
        endcase
        return b;
    endfunction

    // Exact x / 255 for x up to 255 * 255: shift estimate, then one correction.
    function automatic logic [LEVEL_W-1:0] div255(input logic [2*LEVEL_W-1:0] x);
        logic [LEVEL_W-1:0]   q0;
        logic [2*LEVEL_W:0]   r;
        q0 = x[2*LEVEL_W-1:LEVEL_W];
        r  = {1'b0, x} - {1'b0, q0, {LEVEL_W{1'b0}}} + {{(LEVEL_W+1){1'b0}}, q0};
        return (r >= (2*LEVEL_W+1)'(FULL_LEVEL)) ? q0 + 1'b1 : q0;
    endfunction

    bk_state_t               state_reg, state_next;
    logic [LEVEL_W-1:0]      bright_reg;
    logic [HUE_W-1:0]        step_reg;
    logic [LEVEL_W-1:0]      base_r_reg, base_r_next;
    logic [LEVEL_W-1:0]      base_g_reg, base_g_next;
    logic [LEVEL_W-1:0]      base_b_reg, base_b_next;
    logic                    blink_mode_reg, blink_mode_next;
    logic                    blink_lit_reg, blink_lit_next;
    logic                    rainbow_mode_reg, rainbow_mode_next;
    logic [HUE_W-1:0]        hue_reg, hue_next;
    logic                    flash_active_reg, flash_active_next;
    logic                    flash_lit_reg, flash_lit_next;
    logic [FLASH_CNT_W-1:0]  flash_count_reg, flash_count_next;
    logic [3*LEVEL_W-1:0]    flash_colour_reg, flash_colour_next;
    logic [HUE_W-1:0]        rem_reg, rem_next;
    logic [2:0]              sector_reg, sector_next;
    logic [LEVEL_W-1:0]      val_reg, val_next;
    logic [LEVEL_W-1:0]      frac_reg, frac_next;
    logic [2*LEVEL_W-1:0]    rise_prod_reg, rise_prod_next;
    logic [2*LEVEL_W-1:0]    fall_prod_reg, fall_prod_next;
    logic                    out_valid_reg;
    logic                    led_write_reg;
    logic [LEVEL_W-1:0]      red_reg, green_reg, blue_reg;

    logic                    out_free;
    logic                    start_hsv;
    logic                    load_out;
    logic                    emit_hsv;
    logic                    res_write;
    logic [LEVEL_W-1:0]      res_red, res_green, res_blue;
    logic [LEVEL_W-1:0]      hsv_red, hsv_green, hsv_blue;
    logic [LEVEL_W-1:0]      rise, fall;
    logic [10:0]             frac_prod;
    logic [HUE_W:0]          hue_sum, hue_wrap1, hue_wrap2;
    base_t                   base_new;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign start_hsv = pop && (item.op == OP_RAINBOW) && rainbow_mode_reg && !flash_active_reg;

    assign cfg.ready     = 1'b1;
    assign rsp.valid     = out_valid_reg;
    assign rsp.led_write = led_write_reg;
    assign rsp.led_red   = red_reg;
    assign rsp.led_green = green_reg;
    assign rsp.led_blue  = blue_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start_hsv) state_next = ST_SECTOR;
            ST_SECTOR: if (rem_reg < SECTOR_DEG) state_next = ST_FRAC;
            ST_FRAC:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        pop      = 1'b0;
        emit_hsv = 1'b0;
        case (state_reg)
            ST_IDLE: pop      = item_valid && out_free;
            ST_EMIT: emit_hsv = out_free;
            default:
            begin
                pop      = 1'b0;
                emit_hsv = 1'b0;
            end
        endcase
    end

    assign load_out = pop && !start_hsv;

    // Hue advance, reduced modulo a full circle
    always_comb
    begin
        hue_sum   = {1'b0, hue_reg} + {1'b0, step_reg};
        hue_wrap1 = (hue_sum >= (HUE_W+1)'(HUE_CIRCLE)) ?
                    hue_sum - (HUE_W+1)'(HUE_CIRCLE) : hue_sum;
        hue_wrap2 = (hue_wrap1 >= (HUE_W+1)'(HUE_CIRCLE)) ?
                    hue_wrap1 - (HUE_W+1)'(HUE_CIRCLE) : hue_wrap1;
    end

    // Item execution
    always_comb
    begin
        base_r_next       = base_r_reg;
        base_g_next       = base_g_reg;
        base_b_next       = base_b_reg;
        blink_mode_next   = blink_mode_reg;
        blink_lit_next    = blink_lit_reg;
        rainbow_mode_next = rainbow_mode_reg;
        hue_next          = hue_reg;
        flash_active_next = flash_active_reg;
        flash_lit_next    = flash_lit_reg;
        flash_count_next  = flash_count_reg;
        flash_colour_next = flash_colour_reg;
        rem_next          = rem_reg;
        sector_next       = sector_reg;
        val_next          = val_reg;
        res_write         = 1'b0;
        res_red           = '0;
        res_green         = '0;
        res_blue          = '0;
        base_new          = refresh_base(item.link_phase, item.recording, item.gps_fix);

        if (pop)
        begin
            case (item.op)
                OP_STATUS:
                begin
                    if (!flash_active_reg)
                    begin
                        base_r_next = base_new.red;
                        base_g_next = base_new.green;
                        base_b_next = base_new.blue;
                        if (!base_new.keep_blink) blink_mode_next = base_new.blink;
                    end
                end
                OP_BLINK:
                begin
                    if (!flash_active_reg && !rainbow_mode_reg)
                    begin
                        res_write = 1'b1;
                        if (!(blink_mode_reg && blink_lit_reg))
                        begin
                            res_red   = base_r_reg;
                            res_green = base_g_reg;
                            res_blue  = base_b_reg;
                        end
                        if (blink_mode_reg) blink_lit_next = !blink_lit_reg;
                    end
                end
                OP_FLASH_TICK:
                begin
                    if (flash_active_reg)
                    begin
                        flash_lit_next = !flash_lit_reg;
                        res_write      = 1'b1;
                        if (!flash_lit_reg)
                        begin
                            res_red   = flash_colour_reg[3*LEVEL_W-1:2*LEVEL_W];
                            res_green = flash_colour_reg[2*LEVEL_W-1:LEVEL_W];
                            res_blue  = flash_colour_reg[LEVEL_W-1:0];
                        end
                        if (flash_count_reg <= FLASH_CNT_W'(1))
                        begin
                            // Last phase: stop and pick up the current status
                            flash_count_next  = '0;
                            flash_active_next = 1'b0;
                            base_r_next       = base_new.red;
                            base_g_next       = base_new.green;
                            base_b_next       = base_new.blue;
                            if (!base_new.keep_blink) blink_mode_next = base_new.blink;
                        end
                        else
                        begin
                            flash_count_next = flash_count_reg - 1'b1;
                        end
                    end
                end
                OP_RAINBOW:
                begin
                    if (start_hsv)
                    begin
                        rem_next    = hue_reg;
                        sector_next = '0;
                        val_next    = bright_reg;
                        hue_next    = hue_wrap2[HUE_W-1:0];
                    end
                end
                OP_FLASH_REQ:
                begin
                    flash_colour_next = item.flash_colour;
                    flash_count_next  = {item.flash_times, 1'b0};
                    flash_lit_next    = 1'b0;
                    flash_active_next = 1'b1;
                end
                OP_SET_RAINBOW:
                begin
                    rainbow_mode_next = item.rainbow_on;
                    if (!item.rainbow_on)
                    begin
                        base_r_next = base_new.red;
                        base_g_next = base_new.green;
                        base_b_next = base_new.blue;
                        if (!base_new.keep_blink) blink_mode_next = base_new.blink;
                    end
                end
                default:
                begin
                    res_write = 1'b0;
                end
            endcase
        end

        // Sector search: one subtraction of a sector width per cycle
        if (state_reg == ST_SECTOR && rem_reg >= SECTOR_DEG)
        begin
            rem_next    = rem_reg - SECTOR_DEG;
            sector_next = sector_reg + 1'b1;
        end
    end

    // HSV datapath: fraction, products, then scale and pick the sector
    always_comb
    begin
        frac_prod      = 11'(rem_reg[5:0]) * 11'd17;
        frac_next      = (state_reg == ST_FRAC) ? frac_prod[9:2] : frac_reg;
        rise_prod_next = rise_prod_reg;
        fall_prod_next = fall_prod_reg;
        if (state_reg == ST_MUL)
        begin
            rise_prod_next = (2*LEVEL_W)'(val_reg) * (2*LEVEL_W)'(frac_reg);
            fall_prod_next = (2*LEVEL_W)'(val_reg) * (2*LEVEL_W)'(FULL_LEVEL - frac_reg);
        end
        rise = div255(rise_prod_reg);
        fall = div255(fall_prod_reg);
        case (sector_reg)
            3'd0:    begin hsv_red = val_reg; hsv_green = rise;    hsv_blue = '0;      end
            3'd1:    begin hsv_red = fall;    hsv_green = val_reg; hsv_blue = '0;      end
            3'd2:    begin hsv_red = '0;      hsv_green = val_reg; hsv_blue = rise;    end
            3'd3:    begin hsv_red = '0;      hsv_green = fall;    hsv_blue = val_reg; end
            3'd4:    begin hsv_red = rise;    hsv_green = '0;      hsv_blue = val_reg; end
            default: begin hsv_red = val_reg; hsv_green = '0;      hsv_blue = fall;    end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            bright_reg       <= BRIGHT_RESET;
            step_reg         <= HUE_STEP_RESET;
            base_r_reg       <= '0;
            base_g_reg       <= '0;
            base_b_reg       <= '0;
            blink_mode_reg   <= 1'b0;
            blink_lit_reg    <= 1'b0;
            rainbow_mode_reg <= 1'b0;
            hue_reg          <= '0;
            flash_active_reg <= 1'b0;
            flash_lit_reg    <= 1'b0;
            flash_count_reg  <= '0;
            flash_colour_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            base_r_reg       <= base_r_next;
            base_g_reg       <= base_g_next;
            base_b_reg       <= base_b_next;
            blink_mode_reg   <= blink_mode_next;
            blink_lit_reg    <= blink_lit_next;
            rainbow_mode_reg <= rainbow_mode_next;
            hue_reg          <= hue_next;
            flash_active_reg <= flash_active_next;
            flash_lit_reg    <= flash_lit_next;
            flash_count_reg  <= flash_count_next;
            flash_colour_reg <= flash_colour_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_BRIGHTNESS: bright_reg <= cfg.data[LEVEL_W-1:0];
                    CFG_HUE_STEP:   step_reg   <= cfg.data[HUE_W-1:0];
                    default:        step_reg   <= step_reg;
                endcase
            end
            if (load_out || emit_hsv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        sector_reg    <= sector_next;
        val_reg       <= val_next;
        frac_reg      <= frac_next;
        rise_prod_reg <= rise_prod_next;
        fall_prod_reg <= fall_prod_next;
        if (load_out)
        begin
            led_write_reg <= res_write;
            red_reg       <= res_red;
            green_reg     <= res_green;
            blue_reg      <= res_blue;
        end
        else if (emit_hsv)
        begin
            led_write_reg <= 1'b1;
            red_reg       <= hsv_red;
            green_reg     <= hsv_green;
            blue_reg      <= hsv_blue;
        end
    end

    a_flash_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !flash_active_reg |-> flash_count_reg == '0)
        else $error("flash count left over with no flash running");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hue_reg < HUE_CIRCLE)
        else $error("hue outside a full circle");

    a_frac_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FRAC |-> rem_reg < SECTOR_DEG && sector_reg < 3'd6)
        else $error("sector search ended with bad remainder");

    a_hsv_mode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> rainbow_mode_reg && !flash_active_reg && !pop)
        else $error("rainbow work running outside rainbow mode");

endmodule

// ===== rtl/core/status_led_sequencer.sv =====
//  channel | role   | beat contents
//  req     | sink   | cmd, link_phase, recording, gps_fix, flash colour, flash_times, rainbow_on
//  cfg     | sink   | index (0 rainbow_brightness, 1 rainbow_hue_step), data
//  rsp     | source | led_write, led_red, led_green, led_blue
//
//  Every request beat yields one response beat. Most commands are executed as they are popped
//  and reach the result register on the next edge; a rainbow tick holds the back end
//  through the hue sector search (one subtraction per cycle), fraction, multiply and emit states.
//  rst_n clears all LED state but the result register data; brightness resets to 64, hue step to 6.
//  While rsp is stalled the QUEUE_DEPTH-entry queue takes that many more req beats,
//  then req.ready drops until the back end pops again.
`timescale 1ns / 1ps

module status_led_sequencer #(
    parameter int QUEUE_DEPTH = sls_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sls_req_if.sink     req,
    sls_cfg_if.sink     cfg,
    sls_rsp_if.source   rsp
);
    import sls_pkg::*;

    logic   push;
    logic   full;
    logic   pop;
    logic   q_valid;
    item_t  front_item;
    item_t  q_item;

    sls_front u_front (
        .req  (req),
        .full (full),
        .push (push),
        .item (front_item)
    );

    sls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .full     (full),
        .pop      (pop),
        .item_out (q_item),
        .valid    (q_valid)
    );

    sls_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (q_item),
        .item_valid (q_valid),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

// ===== tb/sls_led_checker.sv =====
// Watches the LED sequencer channels, predicts each response beat and compares it.
`timescale 1ns / 1ps

module sls_led_checker (
    input  logic clk,
    input  logic rst_n,
    sls_req_if   req,
    sls_cfg_if   cfg,
    sls_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);
    import sls_pkg::*;

    typedef struct packed {
        logic               led_write;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } led_beat_t;

    // Register copies
    logic [LEVEL_W-1:0]   bright;
    logic [HUE_W-1:0]     hue_step;

    // LED state copy
    logic [LEVEL_W-1:0]   base_r;
    logic [LEVEL_W-1:0]   base_g;
    logic [LEVEL_W-1:0]   base_b;
    logic                 blinking;
    logic                 blink_on;
    logic                 rainbow_en;
    logic [HUE_W-1:0]     hue;
    logic                 flashing;
    logic                 flash_on;
    logic [10:0]          flash_left;
    logic [3*LEVEL_W-1:0] flash_rgb;

    led_beat_t led_expect_q[$];
    int        beat_no;

    task automatic report_fail(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string field, input logic [LEVEL_W-1:0] got,
                               input logic [LEVEL_W-1:0] want);
        if (got !== want)
            report_fail($sformatf("LED beat %0d: %s is %0d, expected %0d",
                                  beat_no, field, got, want));
    endtask

    task automatic clear_state();
        bright     = BRIGHT_RESET;
        hue_step   = HUE_STEP_RESET;
        base_r     = '0;
        base_g     = '0;
        base_b     = '0;
        blinking   = 1'b0;
        blink_on   = 1'b0;
        rainbow_en = 1'b0;
        hue        = '0;
        flashing   = 1'b0;
        flash_on   = 1'b0;
        flash_left = '0;
        flash_rgb  = '0;
    endtask

    // Pick the base colour and blink flag from the camera status.
    task automatic update_base(input logic [PHASE_W-1:0] phase, input logic rec,
                               input logic gps);
        case (phase)
            PHASE_DISCONNECTED:
            begin
                blinking = 1'b0;
                {base_r, base_g, base_b} = {DIM_LEVEL, 8'd0, 8'd0};
            end
            PHASE_CONNECTING:
            begin
                blinking = 1'b1;
                {base_r, base_g, base_b} = {8'd0, 8'd0, DIM_LEVEL};
            end
            PHASE_CONNECTED:
            begin
                blinking = rec;
                if (gps)
                    {base_r, base_g, base_b} = {PURPLE_LEVEL, 8'd0, PURPLE_LEVEL};
                else
                    {base_r, base_g, base_b} = {8'd0, DIM_LEVEL, 8'd0};
            end
            // unknown phase: go dark, keep the blink flag
            default: {base_r, base_g, base_b} = '0;
        endcase
    endtask

    // Integer HSV at full saturation.
    function automatic led_beat_t hue_colour(input int h, input int v);
        int full;
        int deg;
        int frac;
        int fall;
        int rise;
        int r;
        int g;
        int b;
        led_beat_t c;
        full = FULL_LEVEL;
        deg  = SECTOR_DEG;
        frac = (h % deg) * full / deg;
        fall = v * (full - frac) / full;
        rise = v * frac / full;
        case (h / deg)
            0:       begin r = v;    g = rise; b = 0;    end
            1:       begin r = fall; g = v;    b = 0;    end
            2:       begin r = 0;    g = v;    b = rise; end
            3:       begin r = 0;    g = fall; b = v;    end
            4:       begin r = rise; g = 0;    b = v;    end
            default: begin r = v;    g = 0;    b = fall; end
        endcase
        c.led_write = 1'b1;
        c.red       = LEVEL_W'(r);
        c.green     = LEVEL_W'(g);
        c.blue      = LEVEL_W'(b);
        return c;
    endfunction

    task automatic predict_led(input logic [CMD_W-1:0] code, input logic [PHASE_W-1:0] phase,
                               input logic rec, input logic gps,
                               input logic [3*LEVEL_W-1:0] colour,
                               input logic [LEVEL_W-1:0] times, input logic rb,
                               output led_beat_t o);
        int hue_sum;
        o = '0;
        case (code)
            CMD_STATUS:
                if (!flashing)
                    update_base(phase, rec, gps);
            CMD_BLINK:
                if (!flashing && !rainbow_en)
                begin
                    if (blinking && blink_on)
                        o = {1'b1, 24'h0};
                    else
                        o = {1'b1, base_r, base_g, base_b};
                    if (blinking)
                        blink_on = !blink_on;
                end
            CMD_FLASH_TICK:
                if (flashing)
                begin
                    flash_on = !flash_on;
                    o = flash_on ? {1'b1, flash_rgb} : {1'b1, 24'h0};
                    if (flash_left <= 11'd1)
                    begin
                        flash_left = '0;
                        flashing   = 1'b0;
                        update_base(phase, rec, gps);
                    end
                    else
                        flash_left = flash_left - 11'd1;
                end
            CMD_RAINBOW:
                if (rainbow_en && !flashing)
                begin
                    o = hue_colour(hue, bright);
                    hue_sum = (int'(hue) + int'(hue_step)) % int'(HUE_CIRCLE);
                    hue = HUE_W'(hue_sum);
                end
            CMD_FLASH_REQ:
            begin
                flash_rgb  = colour;
                flash_left = {2'b00, times, 1'b0};
                flash_on   = 1'b0;
                flashing   = 1'b1;
            end
            CMD_SET_RAINBOW:
            begin
                rainbow_en = rb;
                if (!rb)
                    update_base(phase, rec, gps);
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        led_beat_t want;
        led_beat_t got;
        if (!rst_n)
        begin
            clear_state();
            led_expect_q.delete();
            beat_no    = 0;
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_BRIGHTNESS)
                    bright = cfg.data[LEVEL_W-1:0];
                else if (cfg.index == CFG_HUE_STEP)
                    hue_step = cfg.data[HUE_W-1:0];
            end
            if (req.valid && req.ready)
            begin
                predict_led(req.cmd, req.link_phase, req.recording, req.gps_fix,
                            {req.flash_red, req.flash_green, req.flash_blue},
                            req.flash_times, req.rainbow_on, want);
                led_expect_q.push_back(want);
            end
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.led_write, rsp.led_red, rsp.led_green, rsp.led_blue};
                if (led_expect_q.size() == 0)
                    report_fail($sformatf("LED beat %0d arrived with no request waiting: %b %h",
                                          beat_no, got.led_write, got[23:0]));
                else
                begin
                    want = led_expect_q.pop_front();
                    check_field("led_write", {7'd0, got.led_write}, {7'd0, want.led_write});
                    check_field("led_red", got.red, want.red);
                    check_field("led_green", got.green, want.green);
                    check_field("led_blue", got.blue, want.blue);
                end
                beat_no++;
            end
            pending <= led_expect_q.size();
        end
    end

endmodule

// ===== tb/status_led_sequencer_test.sv =====
// Stimulus, response pacing and verdict for the status LED sequencer.
`timescale 1ns / 1ps

module status_led_sequencer_test;
    import sls_pkg::*;

    localparam logic [PHASE_W-1:0] PHASE_UNKNOWN = 2'd3;
    localparam logic [CMD_W-1:0]   CMD_SPARE_LO  = 3'd6;
    localparam logic [CMD_W-1:0]   CMD_SPARE_HI  = 3'd7;
    localparam int                 SETTINGS_N    = 6;
    localparam int                 ITEMS_PER_SET = 170;
    localparam int                 HOLD_CYCLES   = 300;

    // Some brightness values set a ninth bit that the block must drop.
    localparam logic [CFG_DATA_W-1:0] BRIGHT_SET[SETTINGS_N] =
        '{9'h1FF, 9'h100, 9'd200, 9'd17, 9'h0FF, 9'd0};
    localparam logic [CFG_DATA_W-1:0] STEP_SET[SETTINGS_N] =
        '{9'd359, 9'd1, 9'd0, 9'd360, 9'd511, 9'd6};

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   hold_asks;
    bit   quiet;

    sls_req_if req ();
    sls_cfg_if cfg ();
    sls_rsp_if rsp ();

    status_led_sequencer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cfg   (cfg),
        .rsp   (rsp)
    );

    sls_led_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    task automatic send_beat(input logic [CMD_W-1:0] code,
                             input logic [PHASE_W-1:0] phase = PHASE_DISCONNECTED,
                             input logic rec = 1'b0, input logic gps = 1'b0,
                             input logic [3*LEVEL_W-1:0] colour = '0,
                             input logic [LEVEL_W-1:0] times = '0,
                             input logic rb = 1'b0);
        req.valid       <= 1'b1;
        req.cmd         <= code;
        req.link_phase  <= phase;
        req.recording   <= rec;
        req.gps_fix     <= gps;
        req.flash_red   <= colour[23:16];
        req.flash_green <= colour[15:8];
        req.flash_blue  <= colour[7:0];
        req.flash_times <= times;
        req.rainbow_on  <= rb;
        do
            @(posedge clk);
        while (!req.ready);
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            req.valid <= 1'b0;
            repeat (idle_len()) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every predicted beat has come back.
    task automatic drain_results();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] bright_val,
                              input logic [CFG_DATA_W-1:0] step_val);
        write_reg(CFG_BRIGHTNESS, bright_val);
        write_reg(CFG_HUE_STEP, step_val);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_random();
        int                   pick;
        logic [CMD_W-1:0]     code;
        logic [LEVEL_W-1:0]   times;
        pick = $urandom_range(0, 99);
        if (pick < 14)
            code = CMD_STATUS;
        else if (pick < 32)
            code = CMD_BLINK;
        else if (pick < 54)
            code = CMD_FLASH_TICK;
        else if (pick < 76)
            code = CMD_RAINBOW;
        else if (pick < 86)
            code = CMD_FLASH_REQ;
        else if (pick < 95)
            code = CMD_SET_RAINBOW;
        else
            code = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        // mostly short flashes so that they end and hand back to status mode
        times = ($urandom_range(0, 9) == 0) ? LEVEL_W'($urandom) : LEVEL_W'($urandom_range(0, 4));
        send_beat(code, PHASE_W'($urandom), 1'($urandom), 1'($urandom),
                  (3*LEVEL_W)'($urandom), times, $urandom_range(0, 3) != 0);
    endtask

    task automatic run_directed();
        send_beat(CMD_BLINK);
        send_beat(CMD_STATUS, PHASE_DISCONNECTED);
        send_beat(CMD_BLINK);
        send_beat(CMD_STATUS, PHASE_CONNECTING);
        send_beat(CMD_BLINK);
        send_beat(CMD_BLINK);
        send_beat(CMD_STATUS, PHASE_CONNECTED, 1'b1, 1'b1);
        send_beat(CMD_BLINK);
        send_beat(CMD_STATUS, PHASE_UNKNOWN);
        send_beat(CMD_BLINK);
        send_beat(CMD_STATUS, PHASE_CONNECTED, 1'b0, 1'b0);
        send_beat(CMD_BLINK);
        // flash with status and blink ticks ignored in between
        send_beat(CMD_FLASH_REQ, PHASE_DISCONNECTED, 1'b0, 1'b0, 24'hFFFFFF, 8'd1);
        send_beat(CMD_STATUS, PHASE_CONNECTED, 1'b1, 1'b1);
        send_beat(CMD_BLINK);
        send_beat(CMD_FLASH_TICK);
        send_beat(CMD_FLASH_TICK, PHASE_CONNECTING);
        // restart a long flash with a zero-length one
        send_beat(CMD_FLASH_REQ, PHASE_DISCONNECTED, 1'b0, 1'b0, 24'h123456, 8'd255);
        send_beat(CMD_FLASH_REQ, PHASE_DISCONNECTED, 1'b0, 1'b0, 24'hA5A5A5, 8'd0);
        send_beat(CMD_FLASH_TICK, PHASE_CONNECTED, 1'b1, 1'b0);
        send_beat(CMD_FLASH_TICK);
        send_beat(CMD_RAINBOW);
        send_beat(CMD_SET_RAINBOW, PHASE_DISCONNECTED, 1'b0, 1'b0, '0, '0, 1'b1);
        send_beat(CMD_RAINBOW);
        send_beat(CMD_RAINBOW);
        send_beat(CMD_BLINK);
        send_beat(CMD_STATUS, PHASE_CONNECTING);
        send_beat(CMD_FLASH_REQ, PHASE_DISCONNECTED, 1'b0, 1'b0, 24'h00FF00, 8'd1);
        send_beat(CMD_RAINBOW);
        send_beat(CMD_SET_RAINBOW, PHASE_CONNECTED, 1'b1, 1'b1, '0, '0, 1'b0);
        send_beat(CMD_SPARE_LO);
        send_beat(CMD_SPARE_HI);
    endtask

    // Response side: random stalls, plus long hold-offs on request.
    initial
    begin
        int served;
        served = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != served)
            begin
                served++;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat (idle_len() - 1) @(posedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        req.valid       <= 1'b0;
        req.cmd         <= CMD_STATUS;
        req.link_phase  <= PHASE_DISCONNECTED;
        req.recording   <= 1'b0;
        req.gps_fix     <= 1'b0;
        req.flash_red   <= '0;
        req.flash_green <= '0;
        req.flash_blue  <= '0;
        req.flash_times <= '0;
        req.rainbow_on  <= 1'b0;
        cfg.valid       <= 1'b0;
        cfg.index       <= CFG_BRIGHTNESS;
        cfg.data        <= '0;
        hold_asks       <= 0;
        quiet           <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int set_no = 0; set_no < SETTINGS_N; set_no++)
        begin
            drain_results();
            if (set_no == SETTINGS_N - 1)
                set_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(1, 359)));
            else
                set_config(BRIGHT_SET[set_no], STEP_SET[set_no]);
            quiet <= (set_no == 3);
            // stall the response side while requests keep coming
            if (set_no == 1)
                hold_asks <= hold_asks + 1;
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                send_random();
                if ($urandom_range(0, 79) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== status_led_sequencer.f =====
rtl/core/sls_pkg.sv
rtl/core/sls_if.sv
rtl/core/sls_front.sv
rtl/core/sls_queue.sv
rtl/core/sls_back.sv
rtl/core/status_led_sequencer.sv
tb/sls_led_checker.sv
tb/status_led_sequencer_test.sv
